[sv/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants of the line fit unit
// Index, count and wide intermediate widths; status codes; request record.
// ----------------------------------------------------------------------------
`default_nettype none
package lsf_pkg;
	localparam int MAX_POINTS = 64;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int WW = 128;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_CONSTX = 2'd2;
	localparam logic [1:0] ST_DROP = 2'd3;

	// one accepted point request passed from front to back
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic last;
	} lsf_req_t;
endpackage
`default_nettype wire

[sv/least_squares_line_fit_unit.sv]
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit: ordinary least-squares line fit
// Accepts Q16.16 points, fits a line on the closing point, emits results.
// ----------------------------------------------------------------------------
// Points enter through a two-deep request queue into the back end, which
// stores each point and folds it into the sums using one shared shift-add
// multiplier (two products per point). On the request carrying last_point
// the back end runs the fit: four serial multiplies and two restoring
// divides, then per point one multiply, one divide and two multiplies,
// then a multiply and a divide for the determination coefficient and a
// divide plus a 32-step root for the residual sigma. Results then leave
// while out_ready is high, each after a read state for its stored
// prediction. Fewer than two points or constant x gives a single zero
// result with status.
`default_nettype none
module least_squares_line_fit_unit import lsf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [31:0] x_value,
	input wire logic signed [31:0] y_value,
	input wire logic last_point,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] point_index,
	output logic signed [31:0] predicted,
	output logic signed [31:0] slope,
	output logic signed [31:0] intercept,
	output logic [16:0] determination,
	output logic [31:0] resid_sigma,
	output logic [1:0] status,
	output logic last_result
);
	lsf_req_t in_req, q_req;
	logic q_valid, q_ready;

	assign in_req = '{x: x_value, y: y_value, last: last_point};

	lsf_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
	);

	lsf_core u_core (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.res_valid(out_valid), .res_ready(out_ready),
		.res_index(point_index), .res_pred(predicted), .res_slope(slope),
		.res_icpt(intercept), .res_r2(determination), .res_se(resid_sigma),
		.res_status(status), .res_last(last_result)
	);

	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FEW || status == ST_CONSTX) |-> last_result)
		else $error("special result not last");
	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FEW |-> slope == 0 && point_index == 0)
		else $error("too-few result not zero");
	a_r2_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> determination <= 17'd65536)
		else $error("determination above one");
endmodule
`default_nettype wire

[sv/lsf_fifo.sv]
// ----------------------------------------------------------------------------
// lsf_fifo: two-entry request queue
// Decouples the accepting front from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none
module lsf_fifo import lsf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire lsf_req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output lsf_req_t out_data
);
	lsf_req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

[sv/lsf_core.sv]
// ----------------------------------------------------------------------------
// lsf_core: point store, sum accumulation and fit sequencer
// Serial multiplier, divider and root; emits one result per point (one for a special case).
// ----------------------------------------------------------------------------
`default_nettype none
module lsf_core import lsf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire lsf_req_t req,
	output logic res_valid,
	input wire logic res_ready,
	output logic [5:0] res_index,
	output logic signed [31:0] res_pred,
	output logic signed [31:0] res_slope,
	output logic signed [31:0] res_icpt,
	output logic [16:0] res_r2,
	output logic [31:0] res_se,
	output logic [1:0] res_status,
	output logic res_last
);
	localparam logic [4:0] S_LOAD = 5'd0, S_XY = 5'd1, S_XX = 5'd2, S_A1 = 5'd3,
		S_A2 = 5'd4, S_B1 = 5'd5, S_B2 = 5'd6, S_I1 = 5'd7, S_I2 = 5'd8,
		S_CHK = 5'd9, S_SL = 5'd10, S_IC = 5'd11, S_RD = 5'd12, S_PX = 5'd13,
		S_PD = 5'd14, S_PE = 5'd15, S_PT = 5'd16, S_R2M = 5'd17, S_R2D = 5'd18,
		S_SED = 5'd19, S_SQ = 5'd20, S_OUT = 5'd21, S_ORD = 5'd22, S_SPC = 5'd23,
		S_DIV = 5'd24, S_MUL = 5'd25;

	logic [4:0] st_q, ret_q, mret_q;
	logic signed [31:0] xmem [MAX_POINTS];
	logic signed [31:0] ymem [MAX_POINTS];
	logic signed [31:0] pmem [MAX_POINTS];
	logic signed [31:0] xr_q, yr_q;
	logic signed [31:0] xin_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] i_q;
	logic ovf_q;
	logic signed [39:0] sx_q, sy_q;
	logic signed [55:0] sxy_q, sxx_q;
	logic signed [WW-1:0] a_q, b_q, ic_q, t_q, r_q, tmp_q;
	logic signed [31:0] slope_q, icpt_q, pred_q;
	logic [16:0] r2_q;
	logic [31:0] se_q;
	logic [1:0] stat_q;
	// shift-add multiplier, signed 128 x 128 -> low 128
	logic [WW-1:0] ma_q, mb_q, mp_q;
	logic [6:0] mc_q;
	// restoring divider, rounded by pre-scaling the operands
	logic [WW-1:0] dn_q, dd_q, dq_q, drem_q;
	logic [6:0] dc_q;
	logic dneg_q;
	logic [WW-1:0] dres;
	logic [WW:0] dtrial;
	// digit-by-digit root, two radicand bits per step
	logic [63:0] sqv_q;
	logic [31:0] sqr_q;
	logic [33:0] sqrem_q;
	logic [4:0] sqb_q;
	logic [36:0] sqtrial;

	function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
		if (v < -(128'sd2147483648)) return 32'sh80000000;
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		return v[31:0];
	endfunction

	assign req_ready = (st_q == S_LOAD);
	assign res_valid = (st_q == S_OUT) || (st_q == S_SPC);
	assign dtrial = {drem_q, dn_q[WW-1]} - {1'b0, dd_q};
	assign sqtrial = {1'b0, sqrem_q, sqv_q[63:62]} - {3'b000, sqr_q, 2'b01};

	always_ff @(posedge clk) begin
		if (st_q == S_LOAD && req_valid && cnt_q < CNT_W'(MAX_POINTS)) begin
			xmem[cnt_q[IDX_W-1:0]] <= req.x;
			ymem[cnt_q[IDX_W-1:0]] <= req.y;
		end
		xr_q <= xmem[i_q];
		yr_q <= ymem[i_q];
	end

	// x of the request being loaded, reused for the x*x product
	always_ff @(posedge clk) begin
		if (st_q == S_LOAD) xin_q <= req.x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sx_q <= '0; sy_q <= '0; sxy_q <= '0; sxx_q <= '0;
			i_q <= '0;
		end else begin
			case (st_q)
				S_LOAD: if (req_valid) begin
					if (cnt_q < CNT_W'(MAX_POINTS)) begin
						cnt_q <= cnt_q + 1'b1;
						sx_q <= sx_q + 40'(req.x);
						sy_q <= sy_q + 40'(req.y);
						ma_q <= WW'(req.x); mb_q <= WW'(req.y);
						mp_q <= '0; mc_q <= '0;
						mret_q <= S_XY; st_q <= S_MUL;
						ret_q <= req.last ? S_A1 : S_LOAD;
					end else begin
						ovf_q <= 1'b1;
						if (req.last) st_q <= S_A1;
					end
				end
				S_MUL: begin
					if (mb_q[0]) mp_q <= mp_q + ma_q;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
					mc_q <= mc_q + 1'b1;
					if (mc_q == 7'd127) st_q <= mret_q;
				end
				S_XY: begin
					sxy_q <= sxy_q + 56'($signed(mp_q) >>> 16);
					ma_q <= WW'(xin_q); mb_q <= WW'(xin_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_XX; st_q <= S_MUL;
				end
				S_XX: begin
					sxx_q <= sxx_q + 56'($signed(mp_q) >>> 16);
					st_q <= ret_q;
				end
				S_A1: begin
					ma_q <= WW'(sx_q); mb_q <= WW'(sx_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_A2; st_q <= S_MUL;
				end
				S_A2: begin
					a_q <= (WW'(sxx_q) * WW'(cnt_q) <<< 16) - $signed(mp_q);
					ma_q <= WW'(sx_q); mb_q <= WW'(sy_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_B1; st_q <= S_MUL;
				end
				S_B1: begin
					b_q <= (WW'(sxy_q) * WW'(cnt_q) <<< 16) - $signed(mp_q);
					ma_q <= WW'(sy_q); mb_q <= WW'(sxx_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_B2; st_q <= S_MUL;
				end
				S_B2: begin
					tmp_q <= mp_q;
					ma_q <= WW'(sx_q); mb_q <= WW'(sxy_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_I1; st_q <= S_MUL;
				end
				S_I1: begin
					ic_q <= (tmp_q - $signed(mp_q)) <<< 16;
					st_q <= S_CHK;
				end
				S_CHK: begin
					if (cnt_q < CNT_W'(2) || a_q <= 0) begin
						stat_q <= (cnt_q < CNT_W'(2)) ? ST_FEW : ST_CONSTX;
						st_q <= S_SPC;
					end else begin
						stat_q <= ovf_q ? ST_DROP : ST_OK;
						div_start(b_q <<< 16, a_q);
						ret_q <= S_SL;
					end
				end
				S_SL: begin
					slope_q <= sat32(dres);
					div_start(ic_q, a_q);
					ret_q <= S_IC;
				end
				S_IC: begin
					icpt_q <= sat32(dres);
					t_q <= '0; r_q <= '0; i_q <= '0;
					st_q <= S_RD;
				end
				S_RD: st_q <= S_I2;
				S_I2: begin
					ma_q <= b_q; mb_q <= WW'(xr_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_PX; st_q <= S_MUL;
				end
				S_PX: begin
					div_start($signed(mp_q) + ic_q, a_q);
					ret_q <= S_PD;
				end
				S_PD: begin
					tmp_q <= WW'(yr_q) - WW'(sat32(dres));
					ma_q <= WW'(yr_q) - WW'(sat32(dres));
					mb_q <= WW'(yr_q) - WW'(sat32(dres));
					mp_q <= '0; mc_q <= '0; mret_q <= S_PE; st_q <= S_MUL;
				end
				S_PE: begin
					r_q <= r_q + $signed(mp_q);
					ma_q <= WW'(yr_q) * WW'(cnt_q) - WW'(sy_q);
					mb_q <= WW'(yr_q) * WW'(cnt_q) - WW'(sy_q);
					mp_q <= '0; mc_q <= '0; mret_q <= S_PT; st_q <= S_MUL;
				end
				S_PT: begin
					t_q <= t_q + $signed(mp_q);
					if (CNT_W'(i_q) + 1'b1 == cnt_q) begin
						ma_q <= r_q; mb_q <= WW'(cnt_q) * WW'(cnt_q);
						mp_q <= '0; mc_q <= '0; mret_q <= S_R2M; st_q <= S_MUL;
					end else begin
						i_q <= i_q + 1'b1; st_q <= S_RD;
					end
				end
				S_R2M: begin
					r2_q <= '0;
					if (t_q != 0) begin
						div_start(mp_q << 16, t_q);
						ret_q <= S_R2D;
					end else st_q <= S_R2D;
				end
				S_R2D: begin
					if (t_q != 0 && dres < 128'd65536) r2_q <= 17'(128'd65536 - dres);
					se_q <= '0;
					if (cnt_q > CNT_W'(2)) begin
						dn_q <= r_q; dd_q <= WW'(cnt_q - CNT_W'(2));
						drem_q <= '0; dc_q <= '0; dneg_q <= 1'b0;
						st_q <= S_DIV; ret_q <= S_SED;
					end else begin
						i_q <= '0; st_q <= S_ORD;
					end
				end
				S_SED: begin
					// quotient at or above 2^64 gives a root that saturates anyway
					sqv_q <= (dres[WW-1:64] != 0) ? '1 : dres[63:0];
					sqr_q <= '0; sqrem_q <= '0; sqb_q <= 5'd31; st_q <= S_SQ;
				end
				S_SQ: begin
					if (!sqtrial[36]) sqrem_q <= sqtrial[33:0];
					else sqrem_q <= {sqrem_q[31:0], sqv_q[63:62]};
					sqr_q <= {sqr_q[30:0], ~sqtrial[36]};
					sqv_q <= sqv_q << 2;
					sqb_q <= sqb_q - 1'b1;
					if (sqb_q == 5'd0) begin
						se_q <= {sqr_q[30:0], ~sqtrial[36]};
						i_q <= '0; st_q <= S_ORD;
					end
				end
				S_ORD: st_q <= S_OUT;
				S_DIV: begin
					if (!dtrial[WW]) begin
						drem_q <= dtrial[WW-1:0]; dq_q <= {dq_q[WW-2:0], 1'b1};
					end else begin
						drem_q <= {drem_q[WW-2:0], dn_q[WW-1]}; dq_q <= {dq_q[WW-2:0], 1'b0};
					end
					dn_q <= dn_q << 1;
					dc_q <= dc_q + 1'b1;
					if (dc_q == 7'd127) st_q <= ret_q;
				end
				S_SPC: if (res_ready) begin
					clear_set();
					st_q <= S_LOAD;
				end
				S_OUT: if (res_ready) begin
					if (CNT_W'(i_q) + 1'b1 == cnt_q) begin
						clear_set(); st_q <= S_LOAD;
					end else begin
						i_q <= i_q + 1'b1; st_q <= S_ORD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	task automatic clear_set();
		cnt_q <= '0; ovf_q <= 1'b0;
		sx_q <= '0; sy_q <= '0; sxy_q <= '0; sxx_q <= '0;
	endtask

	// rounded divide: (2|n| + d) / 2d, sign restored on the quotient
	task automatic div_start(input logic signed [WW-1:0] n, input logic signed [WW-1:0] d);
		logic [WW-1:0] m;
		m = n[WW-1] ? WW'(-n) : WW'(n);
		dn_q <= (m << 1) + WW'(d);
		dd_q <= WW'(d) << 1;
		drem_q <= '0; dc_q <= '0;
		dneg_q <= n[WW-1];
		st_q <= S_DIV;
	endtask

	assign dres = dneg_q ? -dq_q : dq_q;

	// per-point predictions are kept in the per-point fit pass; output rereads them
	always_ff @(posedge clk) begin
		if (st_q == S_PD) pmem[i_q] <= sat32(dres);
		pred_q <= pmem[i_q];
	end

	assign res_index = (st_q == S_SPC) ? 6'd0 : 6'(i_q);
	assign res_pred = (st_q == S_SPC) ? '0 : pred_q;
	assign res_slope = (st_q == S_SPC) ? '0 : slope_q;
	assign res_icpt = (st_q == S_SPC) ? '0 : icpt_q;
	assign res_r2 = (st_q == S_SPC) ? '0 : r2_q;
	assign res_se = (st_q == S_SPC) ? '0 : se_q;
	assign res_status = stat_q;
	assign res_last = (st_q == S_SPC) || (CNT_W'(i_q) + 1'b1 == cnt_q);

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS)) else $error("point count above capacity");
	a_spc_stat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SPC |-> (stat_q == ST_FEW || stat_q == ST_CONSTX))
		else $error("special result with ordinary status");
	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_OUT |-> CNT_W'(i_q) < cnt_q) else $error("result index past count");
endmodule
`default_nettype wire
